>>> rtl/core/dlbk_pkg.sv
// ----------------------------------------------------------------------------
// dlbk_pkg: shared types and constants of the dual LFSR block key generator
// Holds the request and response words, the sequencer states, the lane
// control word, the LFSR polynomials and the fixed selector/key table.
// ----------------------------------------------------------------------------
`default_nettype none

package dlbk_pkg;

  localparam int unsigned LfsrWidth = 32;
  localparam int unsigned KeyWidth  = 12;
  localparam int unsigned NumKeys   = 16;
  localparam int unsigned MaxSteps  = 4;

  localparam logic [LfsrWidth-1:0] PolyA   = 32'h8001fff9;
  localparam logic [LfsrWidth-1:0] PolyB   = 32'h8f0f0f0e;
  localparam logic [LfsrWidth-1:0] TapMask = 32'h00110000;

  localparam logic ActInit    = 1'b0;
  localparam logic ActAdvance = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] host_val;
    logic [15:0] stream_key;
    logic [7:0]  key_selector;
    logic [15:0] frame_val;
  } req_word_t;

  typedef struct packed {
    logic [11:0] blk_key;
    logic        bad_selector;
  } rsp_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic load;   // take the seed value
    logic start;  // clear the step and tap counters
    logic run;    // step while the loop condition holds
  } lane_ctrl_t;

  typedef struct packed {
    logic       hit;
    logic [31:0] key;
  } lookup_t;

  typedef logic [7:0]  sel_array_t [NumKeys];
  typedef logic [31:0] key_array_t [NumKeys];

  localparam sel_array_t SelTable = '{
    8'h55, 8'hff, 8'h89, 8'h23, 8'h33, 8'h99, 8'heb, 8'h41,
    8'hef, 8'h45, 8'h2b, 8'h81, 8'h8b, 8'h21, 8'h4b, 8'he1
  };

  localparam key_array_t KeyTable = '{
    32'hc480cc39, 32'h444c4991, 32'h38d13bf2, 32'hf160787d,
    32'h6a7c3b83, 32'h19c832fd, 32'h4e998d9f, 32'hb5bde57b,
    32'hc1c42917, 32'hf8253852, 32'h41d0a606, 32'hd59dc21a,
    32'h989517a1, 32'h508a4265, 32'h7553d94c, 32'h5a83df4f
  };

  // The first matching entry wins.
  function automatic lookup_t key_lookup(input logic [7:0] sel);
    lookup_t res;
    res.hit = 1'b0;
    res.key = '0;
    for (int i = NumKeys - 1; i >= 0; i--) begin
      if (SelTable[i] == sel) begin
        res.hit = 1'b1;
        res.key = KeyTable[i];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/dual_lfsr_block_key_generator_core.sv
// ----------------------------------------------------------------------------
// dual_lfsr_block_key_generator_core: 12-bit block key generator
// An init word looks up the key selector, derives the constant key and seeds
// both LFSRs, then advances once; an advance word steps both LFSRs again.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req, req_valid, req_stall) takes one word per item.
//   The response channel (rsp, rsp_valid, rsp_stall) returns exactly one word
//   per item, carrying the new block key and the bad selector flag.
//   Both LFSR lanes step in parallel, one shift per cycle; each takes two to
//   four shifts depending on its tap bits, so the shift loop sets the rate.
//   An init word with an unknown selector skips the shift loop and changes
//   neither the LFSRs nor the constant and current block keys.
//   One item is in work at a time; req_stall is high in every state but idle,
//   so while it runs and while its finished response waits to be loaded.
//   A stalled response holds its word until it is taken.
//   Synchronous reset clears both LFSRs, the constant key and the current
//   block key to zero and empties the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_lfsr_block_key_generator_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dlbk_pkg::req_word_t req,
  input  wire logic                req_valid,
  output      logic                req_stall,
  output      dlbk_pkg::rsp_word_t rsp,
  output      logic                rsp_valid,
  input  wire logic                rsp_stall
);
  import dlbk_pkg::*;

  seq_state_t state, state_next;
  lane_ctrl_t lane_ctrl;
  lookup_t    lookup;

  logic                 req_accept;
  logic                 rsp_free;
  logic                 is_init;
  logic                 bad;
  logic                 bad_next;
  logic [KeyWidth-1:0]  constant_key;
  logic [KeyWidth-1:0]  constant_key_next;
  logic [KeyWidth-1:0]  current_block_key;
  logic [LfsrWidth-1:0] seed_base;
  logic [LfsrWidth-1:0] seed_a;
  logic [LfsrWidth-1:0] seed_b;
  logic [LfsrWidth-1:0] lfsr_a;
  logic [LfsrWidth-1:0] lfsr_b;
  logic                 active_a;
  logic                 active_b;
  logic                 rsp_load;
  logic                 key_update;

  assign req_accept = req_valid && !req_stall;
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign is_init    = (req.action == ActInit);
  assign lookup     = key_lookup(req.key_selector);

  // Constant key and seeds, from the request word and the table key.
  always_comb begin
    constant_key_next = {4'h0, lookup.key[23:16] & req.stream_key[15:8]}
                      ^ {6'h00, req.stream_key[5:0] & lookup.key[31:26]}
                      ^ {lookup.key[27:24] | req.host_val[3:0], 8'h00}
                      ^ {req.host_val[11:6], 6'h00};
    seed_base = {req.frame_val, 16'h0000} ^ {8'h00, req.host_val, 8'h00}
              ^ {16'h0000, req.stream_key};
    seed_a    = seed_base ^ {12'h000, lookup.key[7:0], 12'h000};
    seed_b    = seed_base ^ {12'h000, lookup.key[15:8], 12'h000};
  end

  dlbk_lfsr_lane u_lane_a (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (lane_ctrl),
    .poly   (PolyA),
    .seed   (seed_a),
    .value  (lfsr_a),
    .active (active_a)
  );

  dlbk_lfsr_lane u_lane_b (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (lane_ctrl),
    .poly   (PolyB),
    .seed   (seed_b),
    .value  (lfsr_b),
    .active (active_b)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_accept) begin
          if (is_init && !lookup.hit) begin
            state_next = S_DONE;
          end else begin
            state_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (!active_a && !active_b) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    req_stall      = 1'b1;
    lane_ctrl      = '0;
    key_update     = 1'b0;
    rsp_load       = 1'b0;
    bad_next       = bad;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_accept) begin
          bad_next = is_init && !lookup.hit;
          if (!is_init || lookup.hit) begin
            lane_ctrl.start = 1'b1;
            lane_ctrl.load  = is_init;
          end
        end
      end
      S_RUN: begin
        lane_ctrl.run = 1'b1;
        key_update    = !active_a && !active_b;
      end
      S_DONE: begin
        rsp_load = rsp_free;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      bad               <= 1'b0;
      constant_key      <= '0;
      current_block_key <= '0;
      rsp_valid         <= 1'b0;
    end else begin
      state <= state_next;
      bad   <= bad_next;
      if (req_accept && is_init && lookup.hit) begin
        constant_key <= constant_key_next;
      end
      if (key_update) begin
        current_block_key <= constant_key ^ lfsr_a[KeyWidth-1:0]
                           ^ {6'h00, lfsr_b[5:0]};
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.blk_key      <= current_block_key;
      rsp.bad_selector <= bad;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dlbk_lfsr_lane.sv
// ----------------------------------------------------------------------------
// dlbk_lfsr_lane: one LFSR with its step sequencer
// Shifts the value right by one position per cycle while run is set, folding
// in the polynomial if bit 0 is set, while steps < MaxSteps and xcount+3 >= 2*steps.
// ----------------------------------------------------------------------------
`default_nettype none

module dlbk_lfsr_lane (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dlbk_pkg::lane_ctrl_t          ctrl,
  input  wire logic [dlbk_pkg::LfsrWidth-1:0] poly,
  input  wire logic [dlbk_pkg::LfsrWidth-1:0] seed,
  output      logic [dlbk_pkg::LfsrWidth-1:0] value,
  output      logic                          active
);
  import dlbk_pkg::*;

  logic [2:0]           steps;
  logic [2:0]           xcount;
  logic [LfsrWidth-1:0] value_next;
  logic                 tap_hit;

  assign tap_hit    = |(value & TapMask);
  assign value_next = (value >> 1) ^ (value[0] ? poly : '0);
  assign active     = (steps != 3'(MaxSteps)) &&
                      (({1'b0, xcount} + 4'd3) >= {steps, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      value  <= '0;
      steps  <= '0;
      xcount <= '0;
    end else begin
      if (ctrl.load) begin
        value <= seed;
      end else if (ctrl.run && active) begin
        value <= value_next;
      end
      if (ctrl.start) begin
        steps  <= '0;
        xcount <= '0;
      end else if (ctrl.run && active) begin
        steps  <= steps + 3'd1;
        xcount <= xcount + {2'b00, tap_hit};
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the dual LFSR block key generator
// Drives init and advance words through the request channel, predicts the
// block key and the bad selector flag of every accepted word, and checks each
// response word against the oldest prediction under varied idling and stalls.
// ----------------------------------------------------------------------------

module tb_top;
  import dlbk_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SegItems   = 88;

  localparam logic [31:0] LanePolyA = 32'h8001fff9;
  localparam logic [31:0] LanePolyB = 32'h8f0f0f0e;
  localparam logic [31:0] LaneTaps  = 32'h00110000;

  localparam logic [7:0] SelCodes [16] = '{
    8'h55, 8'hff, 8'h89, 8'h23, 8'h33, 8'h99, 8'heb, 8'h41,
    8'hef, 8'h45, 8'h2b, 8'h81, 8'h8b, 8'h21, 8'h4b, 8'he1
  };

  localparam logic [31:0] TableKeys [16] = '{
    32'hc480cc39, 32'h444c4991, 32'h38d13bf2, 32'hf160787d,
    32'h6a7c3b83, 32'h19c832fd, 32'h4e998d9f, 32'hb5bde57b,
    32'hc1c42917, 32'hf8253852, 32'h41d0a606, 32'hd59dc21a,
    32'h989517a1, 32'h508a4265, 32'h7553d94c, 32'h5a83df4f
  };

  class key_scoreboard;
    logic [31:0] lane_a;
    logic [31:0] lane_b;
    logic [11:0] base_key;
    logic [11:0] cur_key;
    rsp_word_t   pending_keys[$];
    int          errors;

    function new();
      lane_a   = '0;
      lane_b   = '0;
      base_key = '0;
      cur_key  = '0;
      errors   = 0;
    endfunction

    // Shifts while the tap count keeps up with the step count, 2 to 4 times.
    function logic [31:0] shift_lane(logic [31:0] v, logic [31:0] poly);
      int steps;
      int taps;
      steps = 0;
      taps  = 0;
      while (steps < 4 && taps + 3 >= 2 * steps) begin
        if ((v & LaneTaps) != 0) taps++;
        if (v[0]) v = (v >> 1) ^ poly;
        else v = v >> 1;
        steps++;
      end
      return v;
    endfunction

    function void advance_lanes();
      lane_a  = shift_lane(lane_a, LanePolyA);
      lane_b  = shift_lane(lane_b, LanePolyB);
      cur_key = base_key ^ lane_a[11:0] ^ {6'd0, lane_b[5:0]};
    endfunction

    function void record_request(req_word_t w);
      rsp_word_t   exp_word;
      logic [31:0] tk;
      logic [31:0] seed;
      logic        hit;
      hit = 1'b0;
      tk  = '0;
      exp_word.bad_selector = 1'b0;
      if (w.action == ActInit) begin
        for (int i = 0; i < 16; i++) begin
          if (!hit && SelCodes[i] == w.key_selector) begin
            hit = 1'b1;
            tk  = TableKeys[i];
          end
        end
        if (!hit) begin
          // An unknown selector leaves every register as it was.
          exp_word.bad_selector = 1'b1;
        end else begin
          base_key = ({4'd0, tk[23:16] & w.stream_key[15:8]}
                      ^ {6'd0, w.stream_key[5:0] & tk[31:26]}
                      ^ {tk[27:24] | w.host_val[3:0], 8'd0}
                      ^ {w.host_val[11:6], 6'd0});
          seed   = {w.frame_val, 16'd0} ^ {8'd0, w.host_val, 8'd0}
                 ^ {16'd0, w.stream_key};
          lane_a = seed ^ {12'd0, tk[7:0], 12'd0};
          lane_b = seed ^ {12'd0, tk[15:8], 12'd0};
          advance_lanes();
        end
      end else begin
        advance_lanes();
      end
      exp_word.blk_key = cur_key;
      pending_keys.push_back(exp_word);
    endfunction

    function void check_key_word(rsp_word_t r);
      rsp_word_t e;
      if (pending_keys.size() == 0) begin
        $error("response word with no prediction: blk_key %h bad_selector %b",
               r.blk_key, r.bad_selector);
        errors++;
        return;
      end
      e = pending_keys.pop_front();
      if (r.blk_key !== e.blk_key) begin
        $error("blk_key expected %h actual %h", e.blk_key, r.blk_key);
        errors++;
      end
      if (r.bad_selector !== e.bad_selector) begin
        $error("bad_selector expected %b actual %b", e.bad_selector, r.bad_selector);
        errors++;
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  req_word_t req       = '0;
  logic      req_valid = 1'b0;
  logic      req_stall;
  rsp_word_t rsp;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;

  key_scoreboard sb;
  int            send_idle_pct = 0;
  int            stall_pct     = 0;
  int            cycle_count   = 0;
  int            items_sent    = 0;

  dual_lfsr_block_key_generator_core uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("dual_lfsr_block_key_generator_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) sb.record_request(req);
    if (!rst && rsp_valid && !rsp_stall) sb.check_key_word(rsp);
  end

  function automatic req_word_t make_word(logic act, logic [15:0] host, logic [15:0] stream,
                                          logic [7:0] sel, logic [15:0] frame);
    req_word_t w;
    w.action       = act;
    w.host_val     = host;
    w.stream_key   = stream;
    w.key_selector = sel;
    w.frame_val    = frame;
    return w;
  endfunction

  function automatic req_word_t random_advance();
    return make_word(ActAdvance, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
  endfunction

  // Holds valid low for a random gap, then presents the word until it is taken.
  task automatic send_word(input req_word_t w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
  endtask

  // Mostly an init with a known selector and a run of advances; now and then
  // a random selector, which is usually unknown, or a bare run of advances.
  task automatic run_sequence();
    logic [7:0] sel;
    int         runs;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 80) sel = SelCodes[$urandom_range(15)];
    else sel = 8'($urandom);
    if (pick < 95)
      send_word(make_word(ActInit, 16'($urandom), 16'($urandom), sel, 16'($urandom)));
    runs = $urandom_range(10);
    repeat (runs) send_word(random_advance());
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Advance straight out of reset: both lanes stay at zero.
    send_word(make_word(ActAdvance, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    send_word(make_word(ActAdvance, 16'hffff, 16'hffff, 8'hff, 16'hffff));
    // Unknown selector before and after a good init.
    send_word(make_word(ActInit, 16'hffff, 16'hffff, 8'h00, 16'hffff));
    send_word(make_word(ActInit, 16'hffff, 16'hffff, 8'h55, 16'hffff));
    send_word(make_word(ActAdvance, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    send_word(make_word(ActAdvance, 16'hffff, 16'hffff, 8'hff, 16'hffff));
    send_word(make_word(ActInit, 16'hffff, 16'hffff, 8'hfe, 16'hffff));
    send_word(make_word(ActAdvance, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    send_word(make_word(ActInit, 16'h0000, 16'h0000, 8'hff, 16'h0000));
    send_word(make_word(ActAdvance, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    send_word(make_word(ActInit, 16'hffff, 16'h0000, 8'he1, 16'hffff));
    send_word(make_word(ActAdvance, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    send_word(make_word(ActInit, 16'h0000, 16'hffff, 8'h21, 16'h0000));
    send_word(make_word(ActAdvance, 16'hffff, 16'hffff, 8'hff, 16'hffff));
    send_word(make_word(ActAdvance, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    send_word(make_word(ActInit, 16'h0000, 16'h0000, 8'h01, 16'h0000));
    send_word(make_word(ActAdvance, 16'h0000, 16'h0000, 8'h00, 16'h0000));

    for (int seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 84;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 84;
        end
        default: begin
          send_idle_pct = 8;
          stall_pct     = 8;
        end
      endcase
      items_sent = 0;
      while (items_sent < SegItems) run_sequence();
    end

    req_valid <= 1'b0;
    while (sb.pending_keys.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("dual_lfsr_block_key_generator_core: match");
    end else begin
      $display("dual_lfsr_block_key_generator_core: mismatch");
    end
    $finish;
  end

endmodule
